// File: rtl/lru_pkg.sv
// Shared sizes and types for the LRU page replacement core.
// No dependencies; imported by rtl/lru_page_replacement_core.sv.
package lru_pkg;

	localparam int MAX_FRAMES = 8;
	localparam int PAGE_BITS  = 16;
	localparam int COUNT_W    = 32;
	localparam int CFG_W      = 4;
	localparam int OCC_W      = $clog2(MAX_FRAMES + 1);
	localparam int SLOT_W     = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
	localparam int DATA_W     = 32;
	localparam int ADDR_W     = 3;

	// register byte addresses, word index taken from paddr[2]
	localparam logic REG_FRAMES_IN_USE = 1'b0;

	localparam logic [CFG_W-1:0]   FRAMES_RESET = CFG_W'(8);
	localparam logic [COUNT_W-1:0] COUNT_MAX    = '1;

	typedef logic [PAGE_BITS-1:0] page_t;
	typedef logic [OCC_W-1:0]     occ_t;
	typedef logic [SLOT_W-1:0]    slot_t;
	typedef logic [COUNT_W-1:0]   count_t;

	// lookup outcome for the word in the input register
	typedef struct packed {
		logic  found;
		slot_t pos;
		logic  evict;
		logic  append;
	} lookup_t;

endpackage

// File: rtl/lru_page_replacement_core.sv
// Top level of the LRU page replacement core: input register, tag compare,
// recency shift, saturating counters, result register and APB register.
// Depends on rtl/lru_pkg.sv.
//
//  channel | signals                                   | dir | word
//  --------+-------------------------------------------+-----+-------------------------------
//  req     | req_valid, req_stall, page_number         | in  | one page reference
//  rsp     | rsp_valid, rsp_stall, hit, evicted_valid, | out | hit flag, victim, running
//          | evicted_page, fault_total, hit_total      |     | fault and hit counts
//  apb     | psel, penable, pwrite, paddr, pwdata,     | in  | frames_in_use at byte address 0
//          | prdata, pready                            |     |
//
// One word per cycle sustained while rsp is not stalled; a word's result passes
// from the input register into the result register, which drives rsp. The rate
// is set by the combinational compare of the input word against all resident
// frames followed by the one-position shift of the frame registers. Reset empties the
// frame set, clears both counts and sets frames_in_use to 8. A stall on rsp
// holds the result register and, once the input register is also full, raises
// req_stall in the same cycle.
module lru_page_replacement_core
	import lru_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	// request channel
	input  logic              req_valid,
	output logic              req_stall,
	input  logic [15:0]       page_number,
	// response channel
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output logic              hit,
	output logic              evicted_valid,
	output logic [15:0]       evicted_page,
	output logic [31:0]       fault_total,
	output logic [31:0]       hit_total,
	// register port
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	// ------------------------------------------------------------------
	// Configuration register
	// ------------------------------------------------------------------
	logic [CFG_W-1:0] frames_q;
	logic             cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_FRAMES_IN_USE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_q <= FRAMES_RESET;
		end else if (cfg_wr) begin
			frames_q <= pwdata[CFG_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_FRAMES_IN_USE) begin
			prdata[CFG_W-1:0] = frames_q;
		end
	end

	// clamp capacity: zero acts as one, anything past the frame count saturates
	occ_t cap;
	always_comb begin
		priority if (frames_q == '0) begin
			cap = occ_t'(1);
		end else if (32'(frames_q) > 32'(MAX_FRAMES)) begin
			cap = occ_t'(MAX_FRAMES);
		end else begin
			cap = occ_t'(frames_q);
		end
	end

	// ------------------------------------------------------------------
	// Input register and handshake
	// ------------------------------------------------------------------
	logic  valid_s1;
	page_t page_s1;
	logic  adv;

	// advance the input word whenever the result register is free or draining
	assign adv       = valid_s1 && (!rsp_valid || !rsp_stall);
	assign req_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			page_s1 <= page_number[PAGE_BITS-1:0];
		end
	end

	// ------------------------------------------------------------------
	// Frame set: slot 0 is least recent, slot occ_q-1 most recent
	// ------------------------------------------------------------------
	page_t   frame_q [MAX_FRAMES];
	occ_t    occ_q;
	count_t  fault_q;
	count_t  hit_q;
	lookup_t lk;
	logic [MAX_FRAMES-1:0] match;
	page_t   frame_nxt [MAX_FRAMES];
	slot_t   from;

	// parallel tag compare, lowest matching slot wins
	always_comb begin
		for (int i = 0; i < MAX_FRAMES; i++) begin
			match[i] = (OCC_W'(i) < occ_q) && (frame_q[i] == page_s1);
		end
		lk.found = |match;
		lk.pos   = '0;
		for (int i = MAX_FRAMES - 1; i >= 0; i--) begin
			if (match[i]) begin
				lk.pos = SLOT_W'(i);
			end
		end
		lk.evict  = !lk.found && (occ_q >= cap);
		lk.append = !lk.found && (occ_q < cap);
	end

	// shift younger pages down from the hit slot (or slot 0 on eviction)
	// and drop the referenced page at the most recent end
	always_comb begin
		from = lk.found ? lk.pos : '0;
		for (int i = 0; i < MAX_FRAMES; i++) begin
			frame_nxt[i] = frame_q[i];
			if (lk.found || lk.evict) begin
				if ((SLOT_W'(i) >= from) && (OCC_W'(i + 1) < occ_q)) begin
					frame_nxt[i] = frame_q[(i + 1) % MAX_FRAMES];
				end else if (OCC_W'(i + 1) == occ_q) begin
					frame_nxt[i] = page_s1;
				end
			end else if (OCC_W'(i) == occ_q) begin
				frame_nxt[i] = page_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < MAX_FRAMES; i++) begin
				frame_q[i] <= frame_nxt[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q   <= '0;
			fault_q <= '0;
			hit_q   <= '0;
		end else if (adv) begin
			if (lk.append) begin
				occ_q <= occ_q + occ_t'(1);
			end
			if (lk.found) begin
				if (hit_q != COUNT_MAX) begin
					hit_q <= hit_q + count_t'(1);
				end
			end else if (fault_q != COUNT_MAX) begin
				fault_q <= fault_q + count_t'(1);
			end
		end
	end

	// ------------------------------------------------------------------
	// Result register; the counts change only when a new result loads,
	// so they serve as the count fields directly
	// ------------------------------------------------------------------
	logic  rsp_valid_q;
	logic  hit_flag_q;
	logic  ev_valid_q;
	page_t ev_page_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hit_flag_q <= lk.found;
			ev_valid_q <= lk.evict;
			ev_page_q  <= lk.evict ? frame_q[0] : '0;
		end
	end

	assign rsp_valid     = rsp_valid_q;
	assign hit           = hit_flag_q;
	assign evicted_valid = ev_valid_q;
	assign evicted_page  = 16'(ev_page_q);
	assign fault_total   = fault_q;
	assign hit_total     = hit_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(occ_q) <= 32'(MAX_FRAMES))
		else $error("occupancy beyond frame count");

	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(hit && evicted_valid))
		else $error("hit reported together with an eviction");

	a_append_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && lk.append) |=> (occ_q == $past(occ_q) + occ_t'(1)))
		else $error("append did not grow occupancy");

	a_hit_count: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && lk.found && (hit_q != COUNT_MAX)) |=> (hit_q == $past(hit_q) + count_t'(1)))
		else $error("hit count did not advance");

	a_fault_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && lk.found) |=> $stable(fault_q))
		else $error("fault count moved on a hit");

endmodule
